FILE: hw/rtl/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

    localparam int DEF_CAPACITY  = 8;
    localparam int DEF_ITEM_SIZE = 16;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 5;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_PUSH_LAST = 2'd1,
        CMD_POP       = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_POP  = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mrf_ram.sv
`default_nettype none

module mrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_front.sv
`default_nettype none

module mrf_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         req_type,
    input  wire logic [mrf_pkg::BYTE_W-1:0]   push_byte,
    input  wire logic                         push_last,
    output logic                              cmd_valid,
    input  wire logic                         cmd_ready,
    output mrf_pkg::cmd_t                     cmd
);

    import mrf_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       in_xfer;
    logic       out_xfer;

    // Classify the incoming request.
    always_comb
    begin
        in_cmd.data = push_byte;
        if (req_type)
        begin
            in_cmd.kind = CMD_POP;
        end
        else if (push_last)
        begin
            in_cmd.kind = CMD_PUSH_LAST;
        end
        else
        begin
            in_cmd.kind = CMD_PUSH;
        end
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = in_xfer  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_xfer ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(in_xfer) - 2'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_back.sv
`default_nettype none

module mrf_back #(
    parameter int CAPACITY  = mrf_pkg::DEF_CAPACITY,
    parameter int ITEM_SIZE = mrf_pkg::DEF_ITEM_SIZE
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire mrf_pkg::cmd_t               cmd,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic [mrf_pkg::BYTE_W-1:0]       pop_byte,
    output logic [mrf_pkg::LEN_W-1:0]        msg_length,
    output logic                             last_out,
    output logic                             is_empty,
    output logic                             is_full
);

    import mrf_pkg::*;

    localparam int SW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int FW    = $clog2(ITEM_SIZE + 1);
    localparam int DEPTH = CAPACITY * ITEM_SIZE;
    localparam int AW    = $clog2(DEPTH);

    back_state_t         state_reg, state_next;
    logic [SW-1:0]       wr_slot_reg, wr_slot_next;
    logic [SW-1:0]       rd_slot_reg, rd_slot_next;
    logic [AW-1:0]       wr_base_reg, wr_base_next;
    logic [AW-1:0]       rd_base_reg, rd_base_next;
    logic [AW-1:0]       pop_base_reg, pop_base_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [FW-1:0]       fill_reg, fill_next;
    status_t             err_reg, err_next;
    logic [FW-1:0]       idx_reg, idx_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_full_reg, out_full_next;

    logic                out_free;
    logic                cmd_xfer;
    logic                is_push;
    logic                full_now;
    status_t             err_a, err_b;
    logic                room;
    logic [FW-1:0]       fill_b;
    logic                commit;
    logic                pop_last;
    logic [FW-1:0]       idx_inc;

    logic                byte_wr_en, byte_rd_en;
    logic [AW-1:0]       byte_wr_addr, byte_rd_addr;
    logic [BYTE_W-1:0]   byte_rd_data;
    logic                len_wr_en, len_rd_en;
    logic [FW-1:0]       len_rd_data;

    mrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_wr_addr),
        .wr_data (cmd.data),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data)
    );

    mrf_ram #(
        .WIDTH (FW),
        .DEPTH (CAPACITY)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (wr_slot_reg),
        .wr_data (fill_b),
        .rd_en   (len_rd_en),
        .rd_addr (rd_slot_reg),
        .rd_data (len_rd_data)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign is_push   = (cmd.kind == CMD_PUSH) || (cmd.kind == CMD_PUSH_LAST);
    assign cmd_ready = (state_reg == BK_IDLE) && ((cmd.kind == CMD_PUSH) || out_free);
    assign cmd_xfer  = cmd_valid && cmd_ready;
    assign full_now  = (count_reg == CW'(CAPACITY));

    // A full ring is judged only at the first byte of a message.
    assign err_a   = (fill_reg == '0 && err_reg == STATUS_OK && full_now) ? STATUS_FULL : err_reg;
    assign room    = (fill_reg < FW'(ITEM_SIZE));
    assign err_b   = room ? err_a : STATUS_INVALID;
    assign fill_b  = room ? fill_reg + FW'(1) : fill_reg;
    assign commit  = (err_b == STATUS_OK);

    assign idx_inc  = idx_reg + FW'(1);
    assign pop_last = (len_rd_data == '0) || (idx_inc == len_rd_data);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_xfer && cmd.kind == CMD_POP && count_reg != '0)
                begin
                    state_next = BK_POP;
                end
            end
            BK_POP:
            begin
                if (out_free && pop_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_slot_next    = wr_slot_reg;
        rd_slot_next    = rd_slot_reg;
        wr_base_next    = wr_base_reg;
        rd_base_next    = rd_base_reg;
        pop_base_next   = pop_base_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        err_next        = err_reg;
        idx_next        = idx_reg;
        byte_wr_en      = 1'b0;
        byte_wr_addr    = wr_base_reg + AW'(fill_reg);
        byte_rd_en      = 1'b0;
        byte_rd_addr    = rd_base_reg;
        len_wr_en       = 1'b0;
        len_rd_en       = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_xfer && is_push)
                begin
                    byte_wr_en = room && (err_a == STATUS_OK);
                    fill_next  = fill_b;
                    err_next   = err_b;
                    if (cmd.kind == CMD_PUSH_LAST)
                    begin
                        fill_next = '0;
                        err_next  = STATUS_OK;
                        if (commit)
                        begin
                            len_wr_en    = 1'b1;
                            wr_slot_next = (wr_slot_reg == SW'(CAPACITY - 1)) ?
                                           '0 : wr_slot_reg + SW'(1);
                            wr_base_next = (wr_base_reg == AW'((CAPACITY - 1) * ITEM_SIZE)) ?
                                           '0 : wr_base_reg + AW'(ITEM_SIZE);
                            count_next   = count_reg + CW'(1);
                        end
                        out_valid_next  = 1'b1;
                        out_status_next = err_b;
                        out_byte_next   = '0;
                        out_len_next    = commit ? LEN_W'(fill_b) : '0;
                        out_last_next   = 1'b1;
                        out_empty_next  = (count_next == '0);
                        out_full_next   = (count_next == CW'(CAPACITY));
                    end
                end
                else if (cmd_xfer)
                begin
                    if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_EMPTY;
                        out_byte_next   = '0;
                        out_len_next    = '0;
                        out_last_next   = 1'b1;
                        out_empty_next  = 1'b1;
                        out_full_next   = 1'b0;
                    end
                    else
                    begin
                        // Fetch length and first byte; retire the slot at once.
                        len_rd_en     = 1'b1;
                        byte_rd_en    = 1'b1;
                        pop_base_next = rd_base_reg;
                        idx_next      = '0;
                        rd_slot_next  = (rd_slot_reg == SW'(CAPACITY - 1)) ?
                                        '0 : rd_slot_reg + SW'(1);
                        rd_base_next  = (rd_base_reg == AW'((CAPACITY - 1) * ITEM_SIZE)) ?
                                        '0 : rd_base_reg + AW'(ITEM_SIZE);
                        count_next    = count_reg - CW'(1);
                    end
                end
            end
            BK_POP:
            begin
                byte_rd_addr = pop_base_reg + AW'(idx_inc);
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_byte_next   = (len_rd_data == '0) ? '0 : byte_rd_data;
                    out_len_next    = LEN_W'(len_rd_data);
                    out_last_next   = pop_last;
                    out_empty_next  = (count_reg == '0);
                    out_full_next   = full_now;
                    if (!pop_last)
                    begin
                        byte_rd_en = 1'b1;
                        idx_next   = idx_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            wr_base_reg   <= '0;
            rd_base_reg   <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            wr_base_reg   <= wr_base_next;
            rd_base_reg   <= rd_base_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_base_reg   <= pop_base_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign pop_byte   = out_byte_reg;
    assign msg_length = out_len_reg;
    assign last_out   = out_last_reg;
    assign is_empty   = out_empty_reg;
    assign is_full    = out_full_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/message_ring_fifo_core.sv
`default_nettype none

// Message ring FIFO: CAPACITY fixed slots of ITEM_SIZE bytes hold whole
// messages. Push a message one byte per transfer with push_last on its final
// byte; that byte returns one status result (ok with the length, invalid length
// when the message outgrew a slot, or full when no slot was free as it began),
// and a rejected message leaves nothing behind. A pop returns the oldest message
// as one result per byte, each with the length, last_out on the final byte, or a
// single empty result. Every result carries is_empty and is_full as they stand
// after that request. Requests pass a two-entry command queue into the executor,
// so the queue holds up to two requests while the executor or the result port
// stalls. A pop first makes a registered read of the slot length and first byte
// from the slot RAMs, then returns one byte per cycle, as long as the result port
// takes them, from the single read port of the byte RAM. Storage needs no
// initialization after reset.
module message_ring_fifo_core #(
    parameter int CAPACITY  = mrf_pkg::DEF_CAPACITY,
    parameter int ITEM_SIZE = mrf_pkg::DEF_ITEM_SIZE
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        req_type,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  push_byte,
    input  wire logic                        push_last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic [mrf_pkg::BYTE_W-1:0]       pop_byte,
    output logic [mrf_pkg::LEN_W-1:0]        msg_length,
    output logic                             last_out,
    output logic                             is_empty,
    output logic                             is_full
);

    import mrf_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    mrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .push_byte (push_byte),
        .push_last (push_last),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mrf_back #(
        .CAPACITY  (CAPACITY),
        .ITEM_SIZE (ITEM_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .pop_byte   (pop_byte),
        .msg_length (msg_length),
        .last_out   (last_out),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule

`default_nettype wire
